FILE: design/lts_pkg.sv
`default_nettype none

package lts_pkg;

   // Token length counter saturates here
   localparam int MAX_TOKEN_LEN = 255;
   localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int LEN_W         = 8;

   // Reserved word table
   localparam int KW_NUM     = 9;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);

   localparam logic [KW_NUM-1:0] KW_ALL = '1;

   localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
      '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"d", "o", "b", "l", "e", 8'h00},
      '{"b", "o", "o", "l", 8'h00, 8'h00},
      '{"s", "t", "r", "i", "n", "g"}
   };

   localparam logic [KW_IDX_W:0] KW_LEN [KW_NUM] = '{
      4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd5, 4'd4, 4'd6
   };

   // Token classes
   typedef logic [3:0] class_type;

   localparam class_type CLS_KEYWORD = 4'd0;
   localparam class_type CLS_IDENT   = 4'd1;
   localparam class_type CLS_INTEGER = 4'd2;
   localparam class_type CLS_DECIMAL = 4'd3;
   localparam class_type CLS_RELOP   = 4'd4;
   localparam class_type CLS_LPAREN  = 4'd5;
   localparam class_type CLS_RPAREN  = 4'd6;
   localparam class_type CLS_ARITH   = 4'd7;
   localparam class_type CLS_LBRACE  = 4'd8;
   localparam class_type CLS_RBRACE  = 4'd9;
   localparam class_type CLS_COMMA   = 4'd10;
   localparam class_type CLS_SEMI    = 4'd11;
   localparam class_type CLS_QUOTE   = 4'd12;
   localparam class_type CLS_ERROR   = 4'd13;

   // One result transfer
   typedef struct packed {
      class_type        token_class;
      logic             halted;
      logic [7:0]       bad_char;
      logic [LEN_W-1:0] token_length;
   } result_type;

   localparam int RSP_DATA_W = 24;

   // Character classes
   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_letter(c) || is_digit(c);
   endfunction

   function automatic logic ident_end(input logic [7:0] c);
      return c == " " || c == "=" || c == ";" || c == ")" || c == "(" || c == "+" ||
             c == "-" || c == "*" || c == "/" || c == ">" || c == "<" || c == ",";
   endfunction

   function automatic logic number_end(input logic [7:0] c);
      return c == " " || c == ";" || c == ")" || c == "+" || c == "-" ||
             c == "*" || c == "/" || c == ">" || c == "<";
   endfunction

   // Drop every reserved word that cannot match once c lands at position cnt
   function automatic logic [KW_NUM-1:0] kw_update(input logic [KW_NUM-1:0] cand,
                                                   input logic [CNT_W-1:0] cnt,
                                                   input logic [7:0]       c);
      logic [KW_NUM-1:0] keep;
      keep = '0;
      for (int k = 0; k < KW_NUM; k++) begin
         if (cand[k] && cnt < CNT_W'(KW_LEN[k])) begin
            keep[k] = (KW_TEXT[k][cnt[KW_IDX_W-1:0]] == c);
         end
      end
      return keep;
   endfunction

   function automatic logic kw_hit(input logic [KW_NUM-1:0] cand,
                                   input logic [CNT_W-1:0]  cnt);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < KW_NUM; k++) begin
         if (cand[k] && cnt == CNT_W'(KW_LEN[k])) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

FILE: design/lexical_token_scanner_core.sv
// A result is formed from the byte that finishes its token and is registered in the output
// register, or in the skid entry if the output is stalled. Throughput: one byte per cycle;
// the state update and result are combinational; a two-entry output (result register plus
// skid) keeps req_tready free of rsp_tready. req_tready drops only while the skid is occupied.
// Reset: synchronous, active high; returns the scanner to idle, clears the length, rearms
// all reserved-word candidates, clears the halt flag and empties the output.
`default_nettype none

module lexical_token_scanner_core
   import lts_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // Input byte stream
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [7:0]            req_tdata,   // [7:0] char_in
   // Token stream
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] token_length, [15:8] bad_char,
                                              // [16] halted, [23:17] zero
   output logic [3:0]            rsp_tuser    // [3:0] token_class
);

   // Scanner states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_IDENT  = 4'd1;
   localparam logic [3:0] S_INT    = 4'd2;
   localparam logic [3:0] S_COMMA  = 4'd3;
   localparam logic [3:0] S_DEC    = 4'd4;
   localparam logic [3:0] S_REL    = 4'd5;
   localparam logic [3:0] S_BANG   = 4'd6;
   localparam logic [3:0] S_REL2   = 4'd7;
   localparam logic [3:0] S_LPAR   = 4'd8;
   localparam logic [3:0] S_RPAR   = 4'd9;
   localparam logic [3:0] S_ARITH  = 4'd10;
   localparam logic [3:0] S_LBRACE = 4'd11;
   localparam logic [3:0] S_RBRACE = 4'd12;
   localparam logic [3:0] S_SEP    = 4'd13;
   localparam logic [3:0] S_SEMI   = 4'd14;
   localparam logic [3:0] S_QUOTE  = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KW_NUM-1:0] cand_ff, cand_in;
   logic              stop_ff, stop_in;

   result_type        main_ff, main_in;
   result_type        skid_ff, skid_in;
   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;

   logic              accept;
   logic              has_res;
   result_type        res;
   logic [7:0]        c;
   logic [3:0]        start_state;
   logic              consume;
   logic [3:0]        consume_state;
   logic              track_kw;
   logic              ends;
   class_type         end_class;
   logic              halt_after;
   logic [CNT_W-1:0]  count_inc;
   logic [LEN_W-1:0]  length_sat;
   logic              main_free;

   assign c          = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign count_inc  = (count_ff == CNT_W'(MAX_TOKEN_LEN)) ? count_ff : count_ff + 1'b1;
   assign length_sat = (count_ff > CNT_W'(255)) ? 8'hFF : count_ff[LEN_W-1:0];

   // Token start decode from idle
   always_comb begin
      start_state = S_IDLE;
      if (is_letter(c)) begin
         start_state = S_IDENT;
      end else if (is_digit(c)) begin
         start_state = S_INT;
      end else begin
         case (c)
            "<", ">", "=":      start_state = S_REL;
            "!":                start_state = S_BANG;
            "(":                start_state = S_LPAR;
            ")":                start_state = S_RPAR;
            "+", "-", "*", "/": start_state = S_ARITH;
            "{":                start_state = S_LBRACE;
            "}":                start_state = S_RBRACE;
            ",":                start_state = S_SEP;
            ";":                start_state = S_SEMI;
            "\"":               start_state = S_QUOTE;
            default:            start_state = S_IDLE;
         endcase
      end
   end

   // Per-state follower check
   always_comb begin
      consume       = 1'b0;
      consume_state = state_ff;
      track_kw      = 1'b0;
      ends          = 1'b0;
      end_class     = CLS_ERROR;
      halt_after    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_IDENT: begin
            if (is_alnum(c)) begin
               consume  = 1'b1;
               track_kw = 1'b1;
            end else if (ident_end(c)) begin
               ends      = 1'b1;
               end_class = kw_hit(cand_ff, count_ff) ? CLS_KEYWORD : CLS_IDENT;
            end
         end
         S_INT: begin
            if (is_alnum(c)) begin
               consume = 1'b1;
            end else if (c == ",") begin
               consume       = 1'b1;
               consume_state = S_COMMA;
            end else if (number_end(c)) begin
               ends      = 1'b1;
               end_class = CLS_INTEGER;
            end
         end
         S_COMMA: begin
            if (is_alnum(c)) begin
               consume       = 1'b1;
               consume_state = S_DEC;
            end
         end
         S_DEC: begin
            if (is_alnum(c)) begin
               consume = 1'b1;
            end else if (number_end(c)) begin
               ends      = 1'b1;
               end_class = CLS_DECIMAL;
            end
         end
         S_REL: begin
            if (c == "=") begin
               consume       = 1'b1;
               consume_state = S_REL2;
            end else if (c == " " || is_alnum(c)) begin
               ends      = 1'b1;
               end_class = CLS_RELOP;
            end
         end
         S_BANG: begin
            if (c == "=") begin
               consume       = 1'b1;
               consume_state = S_REL2;
            end
         end
         S_REL2: begin
            ends      = (c == " " || is_alnum(c));
            end_class = CLS_RELOP;
         end
         S_LPAR: begin
            ends      = (c == " " || is_alnum(c));
            end_class = CLS_LPAREN;
         end
         S_RPAR: begin
            ends      = (c == " " || c == "{" || c == "}" || c == "," || c == "=");
            end_class = CLS_RPAREN;
         end
         S_ARITH: begin
            ends      = (c == " " || is_alnum(c));
            end_class = CLS_ARITH;
         end
         S_LBRACE: begin
            ends      = (c == " " || c == "\n" || is_alnum(c));
            end_class = CLS_LBRACE;
         end
         S_RBRACE: begin
            // closing brace: an odd follower other than 8'hFF still emits the brace, then halts
            end_class = CLS_RBRACE;
            if (c == " " || c == "\n" || is_alnum(c)) begin
               ends = 1'b1;
            end else if (c != 8'hFF) begin
               ends       = 1'b1;
               halt_after = 1'b1;
            end
         end
         S_SEP: begin
            ends      = (c == " " || is_alnum(c));
            end_class = CLS_COMMA;
         end
         S_SEMI: begin
            ends      = (c == " " || c == "}" || c == "\n" || is_alnum(c));
            end_class = CLS_SEMI;
         end
         S_QUOTE: begin
            ends      = (c == " " || c == "," || c == ")" || is_alnum(c));
            end_class = CLS_QUOTE;
         end
         default: begin
         end
      endcase
   end

   // Next scanner state and result
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cand_in  = cand_ff;
      stop_in  = stop_ff;
      has_res  = 1'b0;
      res      = '0;
      if (accept && !stop_ff) begin
         if (state_ff != S_IDLE && consume) begin
            state_in = consume_state;
            count_in = count_inc;
            if (track_kw) begin
               cand_in = kw_update(cand_ff, count_ff, c);
            end
         end else if (state_ff != S_IDLE && !ends) begin
            // lexical error
            has_res          = 1'b1;
            res.token_class  = CLS_ERROR;
            res.token_length = length_sat;
            res.bad_char     = c;
            res.halted       = 1'b1;
            stop_in          = 1'b1;
            state_in         = S_IDLE;
            count_in         = '0;
            cand_in          = KW_ALL;
         end else if (state_ff != S_IDLE && halt_after) begin
            has_res          = 1'b1;
            res.token_class  = end_class;
            res.token_length = length_sat;
            res.halted       = 1'b1;
            stop_in          = 1'b1;
            state_in         = S_IDLE;
            count_in         = '0;
            cand_in          = KW_ALL;
         end else begin
            // token done (or idle): re-examine the byte from idle
            has_res          = (state_ff != S_IDLE);
            res.token_class  = end_class;
            res.token_length = length_sat;
            state_in         = start_state;
            count_in         = (start_state != S_IDLE) ? CNT_W'(1) : '0;
            cand_in          = is_letter(c) ? kw_update(KW_ALL, '0, c) : KW_ALL;
         end
      end
   end

   // Output register plus skid entry
   assign main_free = !main_valid_ff || rsp_tready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = res;
            main_valid_in = has_res;
         end
      end else if (has_res) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         cand_ff       <= KW_ALL;
         stop_ff       <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cand_ff       <= cand_in;
         stop_ff       <= stop_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.token_class;
   assign rsp_tdata  = {7'b0, main_ff.halted, main_ff.bad_char, main_ff.token_length};

endmodule

`default_nettype wire

FILE: design/lts_checker.sv
`default_nettype none

module lts_checker
   import lts_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_tready,
   input wire                  rsp_tvalid,
   input wire                  rsp_tready,
   input wire [RSP_DATA_W-1:0] rsp_tdata,
   input wire [3:0]            rsp_tuser
);

   // A stalled transfer holds its token
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   // Output is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Every lexical error halts the scanner
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CLS_ERROR |-> rsp_tdata[16])
      else $error("error token without halt");

   // Only an error carries an offending byte
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != CLS_ERROR |-> rsp_tdata[15:8] == 8'h00)
      else $error("bad_char set on a good token");

   // Input is taken whenever the output was empty in this and the previous cycle
   a_ready_after_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(rsp_tvalid) && $past(!reset) |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind lexical_token_scanner_core lts_checker u_lts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
